@@ sv/lcn_pkg.sv @@
// Package for the local contrast normalizer.
// Shared constants, register indexes and the sequencer state type.
package lcn_pkg;

   localparam int LCN_MAX_KERNEL = 9;
   localparam int LCN_MAX_LINE   = 1024;
   localparam int LCN_PIXEL_BITS = 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int LW_BITS    = 11;
   localparam int KREG_BITS  = 4;
   localparam int ROW_BITS   = 10;
   localparam int OUT_BITS   = 16;
   localparam int FRAC_SHIFT = 20;
   localparam int VAR_SHIFT  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS          = 2'd3;

   localparam logic [LW_BITS-1:0]    LINE_WIDTH_RESET = 11'd1024;
   localparam logic [KREG_BITS-1:0]  KERNEL_RESET     = 4'd3;
   localparam logic [CSR_DATA_W-1:0] BIAS_RESET       = 16'd256;
   localparam logic [ROW_BITS-1:0]   ROW_LIMIT        = 10'd1023;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COL,
      ST_WIN,
      ST_MUL1,
      ST_DSET1,
      ST_DIV1,
      ST_SQSET,
      ST_SQRT,
      ST_MUL2,
      ST_DSET2,
      ST_DIV2,
      ST_DONE
   } state_type;

endpackage

@@ sv/lcn_if.sv @@
// Request and response channel interfaces of the local contrast normalizer.
// Depends on lcn_pkg for field widths.
interface lcn_req_if #(parameter int PIXEL_BITS = lcn_pkg::LCN_PIXEL_BITS);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel;
   logic                  frame_start;
   modport source (output valid, pixel, frame_start, input ready);
   modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface lcn_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lcn_pkg::OUT_BITS-1:0]  normalized;
   logic [lcn_pkg::ROW_BITS-1:0]         out_row;
   logic [lcn_pkg::ROW_BITS-1:0]         out_col;
   logic                                 saturated;
   modport source (output valid, normalized, out_row, out_col, saturated, input ready);
   modport sink   (input valid, normalized, out_row, out_col, saturated, output ready);
endinterface

@@ sv/local_contrast_normalize.sv @@
// Local contrast normalizer: one request at a time. A request with no result returns to
// idle after its column update; one with a result also sums the window, divides with a
// bit-serial divider W bits wide (46 at 8-bit pixels, 9x9 kernel), takes an R-step
// square root (23) and, unless the denominator is zero, divides again. The divider and
// the square root unit work one bit per cycle. Line buffers sit in one memory word per
// column holding the previous rows. A finished result waits in the output register
// while the next request is taken. Uses lcn_pkg and lcn_if.
module local_contrast_normalize #(
   parameter int MAX_KERNEL = lcn_pkg::LCN_MAX_KERNEL,
   parameter int MAX_LINE   = lcn_pkg::LCN_MAX_LINE,
   parameter int PIXEL_BITS = lcn_pkg::LCN_PIXEL_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   lcn_req_if.sink                          req,
   lcn_rsp_if.source                        rsp,
   input  logic                             csr_we,
   input  logic [lcn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lcn_pkg::CSR_DATA_W-1:0]   csr_data
);
   import lcn_pkg::*;

   localparam int KB   = $clog2(MAX_KERNEL + 1);
   localparam int NB   = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
   localparam int AW   = $clog2(MAX_LINE);
   localparam int LWW  = $clog2(MAX_LINE + 1);
   localparam int CW   = (LWW > LW_BITS) ? LWW : LW_BITS;
   localparam int MW   = (MAX_KERNEL - 1) * PIXEL_BITS;
   localparam int VW   = MAX_KERNEL * PIXEL_BITS;
   localparam int CSW  = PIXEL_BITS + KB;
   localparam int CQW  = 2 * PIXEL_BITS + KB;
   localparam int SW   = PIXEL_BITS + NB;
   localparam int QW   = 2 * PIXEL_BITS + NB;
   localparam int DW   = QW + NB;
   localparam int DIVW = DW + VAR_SHIFT;
   localparam int RW   = (DIVW + 1) / 2;
   localparam int DENW = RW + 1;
   localparam int NDW  = NB + DENW;
   localparam int DCW  = $clog2(DIVW + 1);

   // configuration
   logic [LW_BITS-1:0]    lw_ff;
   logic [KREG_BITS-1:0]  kh_ff, kw_ff;
   logic [CSR_DATA_W-1:0] bias_ff;
   logic [CW-1:0]         lw_ext, lw_c;
   logic [KREG_BITS-1:0]  kh4, kw4;
   logic [KB-1:0]         kh_c, kw_c, rc, cc;

   // counters and item
   logic [AW-1:0]         col_ff, cur_c;
   logic [ROW_BITS-1:0]   row_ff, cur_r;
   logic [PIXEL_BITS-1:0] pix_ff;
   logic [AW-1:0]         c_ff;
   logic [ROW_BITS-1:0]   r_ff;
   logic                  prod_ff, produce;
   logic                  last_col;
   logic [NB-1:0]         n_ff;

   // memory
   logic [MW-1:0]         mem [MAX_LINE];
   logic [MW-1:0]         rd_ff;
   logic [VW-1:0]         vec;

   // window accumulation
   logic [KB-1:0]         k_ff, j_ff;
   logic [CSW-1:0]        cs_ff, cs_sum;
   logic [CQW-1:0]        cq_ff, cq_sum;
   logic [PIXEL_BITS-1:0] x, cen_ff, cen_new;
   logic [CSW-1:0]        col_s [MAX_KERNEL];
   logic [CQW-1:0]        col_q [MAX_KERNEL];
   logic [PIXEL_BITS-1:0] cen_row [MAX_KERNEL];
   logic [SW-1:0]         s_ff;
   logic [QW-1:0]         q_ff;

   // arithmetic
   logic [DW-1:0]         nq_ff, ss_ff, d_val;
   logic [2*NB-1:0]       nn1_ff;
   logic [SW-1:0]         ncen_ff, mag_ff;
   logic                  neg_ff, dz_ff;
   logic [NDW-1:0]        nden_ff;
   logic [DENW-1:0]       den;
   logic [DIVW-1:0]       div_quo_ff, div_dvs_ff, div_rem_ff;
   logic [DIVW:0]         rem_sh, diff;
   logic [DCW-1:0]        cnt_ff;
   logic [2*RW-1:0]       sq_v_ff;
   logic [RW:0]           sq_rem_ff;
   logic [RW-1:0]         sq_root_ff;
   logic [RW+2:0]         sq_t, sq_trial;

   // result
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_BITS-1:0] norm_ff, norm_in;
   logic [ROW_BITS-1:0]   orow_ff, ocol_ff;
   logic                  sat_ff, sat_in;

   state_type state_ff, state_in;
   logic accept, mem_we, load_out, k_last, j_last, cnt_last;

   assign lw_ext = CW'(lw_ff);
   assign lw_c   = (lw_ext < CW'(2)) ? CW'(2) :
                   (lw_ext > CW'(MAX_LINE)) ? CW'(MAX_LINE) : lw_ext;
   assign kh4    = (kh_ff == '0) ? KREG_BITS'(1) :
                   (kh_ff > KREG_BITS'(MAX_KERNEL)) ? KREG_BITS'(MAX_KERNEL) : kh_ff;
   assign kw4    = (kw_ff < KREG_BITS'(2)) ? KREG_BITS'(2) :
                   (kw_ff > KREG_BITS'(MAX_KERNEL)) ? KREG_BITS'(MAX_KERNEL) : kw_ff;
   assign kh_c   = KB'(kh4);
   assign kw_c   = KB'(kw4);
   assign rc     = kh_c - KB'(1) - (kh_c >> 1);
   assign cc     = kw_c - KB'(1) - (kw_c >> 1);

   always_comb begin
      cur_c = req.frame_start ? '0 : col_ff;
      cur_r = req.frame_start ? '0 : row_ff;
      if (CW'(cur_c) >= lw_c) begin
         cur_c = '0;
      end
      last_col = (CW'(cur_c) + CW'(1)) >= lw_c;
      produce  = (cur_r >= ROW_BITS'(kh_c) - ROW_BITS'(1)) &&
                 (CW'(cur_c) >= CW'(kw_c) - CW'(1));
   end

   assign vec      = {rd_ff, pix_ff};
   assign x        = vec[k_ff * PIXEL_BITS +: PIXEL_BITS];
   assign cs_sum   = cs_ff + CSW'(x);
   assign cq_sum   = cq_ff + CQW'(x) * CQW'(x);
   assign cen_new  = (k_ff == rc) ? x : cen_ff;
   assign k_last   = (k_ff == kh_c - KB'(1));
   assign j_last   = (j_ff == kw_c - KB'(1));
   assign cnt_last = (cnt_ff == DCW'(1));
   assign d_val    = nq_ff - ss_ff;
   assign den      = DENW'(sq_root_ff) + DENW'(bias_ff);

   assign rem_sh   = {div_rem_ff, div_quo_ff[DIVW-1]};
   assign diff     = rem_sh - {1'b0, div_dvs_ff};
   assign sq_t     = {sq_rem_ff, sq_v_ff[2*RW-1 -: 2]};
   assign sq_trial = (RW+3)'({sq_root_ff, 2'b01});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_COL;
         ST_COL:   if (k_last) state_in = prod_ff ? ST_WIN : ST_IDLE;
         ST_WIN:   if (j_last) state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_DSET1;
         ST_DSET1: state_in = ST_DIV1;
         ST_DIV1:  if (cnt_last) state_in = ST_SQSET;
         ST_SQSET: state_in = ST_SQRT;
         ST_SQRT:  if (cnt_last) state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_DSET2;
         ST_DSET2: state_in = dz_ff ? ST_DONE : ST_DIV2;
         ST_DIV2:  if (cnt_last) state_in = ST_DONE;
         ST_DONE:  if (load_out) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req.ready = (state_ff == ST_IDLE);
      mem_we    = (state_ff == ST_COL) && (k_ff == '0);
      load_out  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);
   end

   assign accept = req.valid && req.ready;

   // result value
   always_comb begin
      sat_in  = 1'b0;
      norm_in = '0;
      if (dz_ff) begin
         sat_in = 1'b1;
      end else if (!neg_ff && div_quo_ff > DIVW'(32767)) begin
         sat_in  = 1'b1;
         norm_in = 16'sh7FFF;
      end else if (neg_ff && div_quo_ff > DIVW'(32768)) begin
         sat_in  = 1'b1;
         norm_in = 16'sh8000;
      end else begin
         norm_in = neg_ff ? -$signed(OUT_BITS'(div_quo_ff)) : $signed(OUT_BITS'(div_quo_ff));
      end
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp.ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lw_ff        <= LINE_WIDTH_RESET;
         kh_ff        <= KERNEL_RESET;
         kw_ff        <= KERNEL_RESET;
         bias_ff      <= BIAS_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_LINE_WIDTH:    lw_ff   <= csr_data[LW_BITS-1:0];
               CSR_KERNEL_HEIGHT: kh_ff   <= csr_data[KREG_BITS-1:0];
               CSR_KERNEL_WIDTH:  kw_ff   <= csr_data[KREG_BITS-1:0];
               CSR_BIAS:          bias_ff <= csr_data;
               default:           bias_ff <= bias_ff;
            endcase
            col_ff <= '0;
            row_ff <= '0;
         end else if (accept) begin
            if (last_col) begin
               col_ff <= '0;
               row_ff <= (cur_r < ROW_LIMIT) ? cur_r + ROW_BITS'(1) : cur_r;
            end else begin
               col_ff <= cur_c + AW'(1);
               row_ff <= cur_r;
            end
         end
      end
   end

   // line buffer memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[c_ff] <= MW'({rd_ff, pix_ff});
      end
      if (accept) begin
         rd_ff <= mem[cur_c];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff  <= req.pixel;
         c_ff    <= cur_c;
         r_ff    <= cur_r;
         prod_ff <= produce;
         n_ff    <= NB'(kh_c) * NB'(kw_c);
         k_ff    <= '0;
         j_ff    <= '0;
         cs_ff   <= '0;
         cq_ff   <= '0;
         s_ff    <= '0;
         q_ff    <= '0;
      end
      unique case (state_ff)
         ST_COL: begin
            k_ff   <= k_ff + KB'(1);
            cs_ff  <= cs_sum;
            cq_ff  <= cq_sum;
            cen_ff <= cen_new;
            if (k_last) begin
               for (int i = MAX_KERNEL - 1; i > 0; i--) begin
                  col_s[i]   <= col_s[i-1];
                  col_q[i]   <= col_q[i-1];
                  cen_row[i] <= cen_row[i-1];
               end
               col_s[0]   <= cs_sum;
               col_q[0]   <= cq_sum;
               cen_row[0] <= cen_new;
            end
         end
         ST_WIN: begin
            j_ff <= j_ff + KB'(1);
            s_ff <= s_ff + SW'(col_s[j_ff]);
            q_ff <= q_ff + QW'(col_q[j_ff]);
         end
         ST_MUL1: begin
            nq_ff   <= DW'(n_ff) * DW'(q_ff);
            ss_ff   <= DW'(s_ff) * DW'(s_ff);
            nn1_ff  <= (2*NB)'(n_ff) * (2*NB)'(n_ff - NB'(1));
            ncen_ff <= SW'(n_ff) * SW'(cen_row[cc]);
         end
         ST_DSET1: begin
            div_quo_ff <= DIVW'({d_val, {VAR_SHIFT{1'b0}}});
            div_dvs_ff <= DIVW'(nn1_ff);
            div_rem_ff <= '0;
            cnt_ff     <= DCW'(DIVW);
         end
         ST_DIV1, ST_DIV2: begin
            cnt_ff <= cnt_ff - DCW'(1);
            if (!diff[DIVW]) begin
               div_rem_ff <= diff[DIVW-1:0];
               div_quo_ff <= {div_quo_ff[DIVW-2:0], 1'b1};
            end else begin
               div_rem_ff <= rem_sh[DIVW-1:0];
               div_quo_ff <= {div_quo_ff[DIVW-2:0], 1'b0};
            end
         end
         ST_SQSET: begin
            sq_v_ff    <= (2*RW)'(div_quo_ff);
            sq_rem_ff  <= '0;
            sq_root_ff <= '0;
            cnt_ff     <= DCW'(RW);
         end
         ST_SQRT: begin
            cnt_ff  <= cnt_ff - DCW'(1);
            sq_v_ff <= {sq_v_ff[2*RW-3:0], 2'b00};
            if (sq_t >= sq_trial) begin
               sq_rem_ff  <= (RW+1)'(sq_t - sq_trial);
               sq_root_ff <= {sq_root_ff[RW-2:0], 1'b1};
            end else begin
               sq_rem_ff  <= (RW+1)'(sq_t);
               sq_root_ff <= {sq_root_ff[RW-2:0], 1'b0};
            end
         end
         ST_MUL2: begin
            nden_ff <= NDW'(n_ff) * NDW'(den);
            dz_ff   <= (den == '0);
            neg_ff  <= ncen_ff < s_ff;
            mag_ff  <= (ncen_ff < s_ff) ? s_ff - ncen_ff : ncen_ff - s_ff;
         end
         ST_DSET2: begin
            div_quo_ff <= DIVW'({mag_ff, {FRAC_SHIFT{1'b0}}});
            div_dvs_ff <= DIVW'(nden_ff);
            div_rem_ff <= '0;
            cnt_ff     <= DCW'(DIVW);
         end
         default: begin
            cnt_ff <= cnt_ff;
         end
      endcase
      if (load_out) begin
         norm_ff <= norm_in;
         sat_ff  <= sat_in;
         orow_ff <= r_ff - ROW_BITS'(kh_c) + ROW_BITS'(1);
         ocol_ff <= ROW_BITS'(c_ff) - ROW_BITS'(kw_c) + ROW_BITS'(1);
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.normalized = norm_ff;
   assign rsp.out_row    = orow_ff;
   assign rsp.out_col    = ocol_ff;
   assign rsp.saturated  = sat_ff;

endmodule

@@ sv/lcn_check.sv @@
// Port-level checks for the local contrast normalizer.
// Bound to local_contrast_normalize; depends on lcn_pkg for widths.
module lcn_check (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [lcn_pkg::OUT_BITS-1:0]      rsp_normalized,
   input logic                              rsp_saturated
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_normalized) && $stable(rsp_saturated))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result appeared right after its request");

endmodule

bind local_contrast_normalize lcn_check u_lcn_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_normalized (rsp.normalized),
   .rsp_saturated  (rsp.saturated)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for local_contrast_normalize: a queued request driver, a response
// monitor and an in-bench window normalization predictor. Depends on lcn_pkg and lcn_if.
module testbench;
   import lcn_pkg::*;

   typedef struct {
      logic [7:0] pixel;
      logic       frame_start;
   } pixel_req_t;

   typedef struct {
      logic signed [15:0] normalized;
      logic [9:0]         out_row;
      logic [9:0]         out_col;
      logic               saturated;
   } norm_result_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   lcn_req_if req_ch ();
   lcn_rsp_if rsp_ch ();

   local_contrast_normalize i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   pixel_req_t   pixel_queue[$];
   norm_result_t expected_results[$];
   bit           failed;
   int unsigned  cycle_count;
   int unsigned  items_queued;

   // predictor state
   logic [7:0]  line_rows [8][1024];
   logic [7:0]  win [9][9];
   int unsigned col_pos, row_pos;
   int unsigned cfg_line_width, cfg_kernel_height, cfg_kernel_width, cfg_bias;

   function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   task automatic normalize_pixel(input logic [7:0] pix, input logic fs);
      int unsigned lw, kh, kw, c;
      logic [7:0] vec [9];
      longint unsigned n, s, q, d, v, den, mag, num, qt, ctr, x;
      longint val;
      bit neg;
      norm_result_t r;
      lw = clampu(cfg_line_width, 2, 1024);
      kh = clampu(cfg_kernel_height, 1, 9);
      kw = clampu(cfg_kernel_width, 2, 9);
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (col_pos >= lw) col_pos = 0;
      c = col_pos;
      vec[0] = pix;
      for (int k = 1; k < 9; k++) vec[k] = line_rows[k-1][c];
      for (int k = 8; k > 1; k--) line_rows[k-1][c] = line_rows[k-2][c];
      line_rows[0][c] = pix;
      for (int k = 0; k < 9; k++) begin
         for (int j = 8; j > 0; j--) win[k][j] = win[k][j-1];
         win[k][0] = vec[k];
      end
      if (row_pos >= kh - 1 && c >= kw - 1) begin
         n = kh * kw;
         s = 0;
         q = 0;
         for (int k = 0; k < kh; k++)
            for (int j = 0; j < kw; j++) begin
               x = win[k][j];
               s += x;
               q += x * x;
            end
         ctr = win[kh - 1 - kh / 2][kw - 1 - kw / 2];
         d = n * q - s * s;
         v = (d << 16) / (n * (n - 1));
         den = int_sqrt(v) + cfg_bias;
         num = n * ctr;
         neg = num < s;
         mag = neg ? (s - num) : (num - s);
         r.saturated = 0;
         if (den == 0) begin
            val = 0;
            r.saturated = 1;
         end else begin
            qt = (mag << 20) / (n * den);
            if (!neg && qt > 32767) begin
               val = 32767;
               r.saturated = 1;
            end else if (neg && qt > 32768) begin
               val = -32768;
               r.saturated = 1;
            end else begin
               val = neg ? -longint'(qt) : longint'(qt);
            end
         end
         r.normalized = val[15:0];
         r.out_row = 10'(row_pos - (kh - 1));
         r.out_col = 10'(c - (kw - 1));
         expected_results.push_back(r);
      end
      if (c + 1 >= lw) begin
         col_pos = 0;
         if (row_pos < 1023) row_pos++;
      end else begin
         col_pos = c + 1;
      end
   endtask

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   wire quiet = (cycle_count % 5000) < 1200;

   // request driver
   always @(posedge clock) begin
      pixel_req_t p;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_ch.valid <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) normalize_pixel(req_ch.pixel, req_ch.frame_start);
         if (!req_ch.valid || req_ch.ready) begin
            if (pixel_queue.size() != 0 && (quiet || $urandom_range(99) >= 23)) begin
               p = pixel_queue.pop_front();
               req_ch.valid <= 1;
               req_ch.pixel <= p.pixel;
               req_ch.frame_start <= p.frame_start;
            end else begin
               req_ch.valid <= 0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      norm_result_t e;
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= quiet || $urandom_range(99) >= 23;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result row %0d col %0d", rsp_ch.out_row, rsp_ch.out_col);
               failed = 1;
            end else begin
               e = expected_results.pop_front();
               if (rsp_ch.normalized !== e.normalized) begin
                  $error("normalized: expected %0d, got %0d", e.normalized, rsp_ch.normalized);
                  failed = 1;
               end
               if (rsp_ch.out_row !== e.out_row) begin
                  $error("out_row: expected %0d, got %0d", e.out_row, rsp_ch.out_row);
                  failed = 1;
               end
               if (rsp_ch.out_col !== e.out_col) begin
                  $error("out_col: expected %0d, got %0d", e.out_col, rsp_ch.out_col);
                  failed = 1;
               end
               if (rsp_ch.saturated !== e.saturated) begin
                  $error("saturated: expected %0d, got %0d", e.saturated, rsp_ch.saturated);
                  failed = 1;
               end
            end
         end
      end
   end

   task automatic wait_idle();
      while (pixel_queue.size() != 0 || req_ch.valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_data <= val[15:0];
      case (idx)
         CSR_LINE_WIDTH:    cfg_line_width = val & 32'h7ff;
         CSR_KERNEL_HEIGHT: cfg_kernel_height = val & 32'hf;
         CSR_KERNEL_WIDTH:  cfg_kernel_width = val & 32'hf;
         default:           cfg_bias = val & 32'hffff;
      endcase
      col_pos = 0;
      row_pos = 0;
      @(posedge clock);
      csr_we <= 0;
   endtask

   function automatic logic [7:0] make_pixel(int mode, logic [7:0] base);
      case (mode)
         0: return 8'($urandom_range(255));
         1: return base;
         2: return $urandom_range(1) ? 8'd255 : 8'd0;
         default: return base + 8'($urandom_range(2));
      endcase
   endfunction

   // one frame sequence under a fresh setting; noise puts stray frame starts mid-frame
   task automatic run_setting(int unsigned lw, int unsigned kh, int unsigned kw,
                              int unsigned bias_val, int unsigned pixels, int mode,
                              int unsigned noise_pct);
      pixel_req_t p;
      logic [7:0] base;
      wait_idle();
      write_csr(CSR_LINE_WIDTH, lw);
      write_csr(CSR_KERNEL_HEIGHT, kh);
      write_csr(CSR_KERNEL_WIDTH, kw);
      write_csr(CSR_BIAS, bias_val);
      base = 8'($urandom_range(253));
      for (int unsigned i = 0; i < pixels; i++) begin
         p.pixel = make_pixel(mode, base);
         p.frame_start = (i == 0) || ($urandom_range(99) < noise_pct);
         pixel_queue.push_back(p);
      end
      items_queued += pixels;
   endtask

   initial begin
      int unsigned kh, kw, lw, b, sel;
      reset = 1;
      csr_we = 0;
      csr_index = CSR_LINE_WIDTH;
      csr_data = '0;
      failed = 0;
      cycle_count = 0;
      items_queued = 0;
      cfg_line_width = LINE_WIDTH_RESET;
      cfg_kernel_height = KERNEL_RESET;
      cfg_kernel_width = KERNEL_RESET;
      cfg_bias = BIAS_RESET;
      col_pos = 0;
      row_pos = 0;
      foreach (line_rows[i, j]) line_rows[i][j] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      repeat (8) @(posedge clock);
      reset <= 0;

      // directed: extremes, zero denominator, clipping, clamped registers, no-result widths
      run_setting(2, 1, 2, 0, 4, 2, 0);
      run_setting(3, 1, 2, 0, 3, 1, 0);
      run_setting(3, 2, 2, 65535, 6, 2, 0);
      run_setting(0, 0, 0, 1, 4, 3, 0);
      run_setting(3, 1, 1, 0, 3, 3, 0);
      run_setting(3, 2, 5, 256, 6, 0, 0);
      run_setting(4, 15, 15, 256, 4, 0, 0);
      run_setting(10, 9, 9, 0, 90, 2, 0);
      run_setting(2047, 1, 9, 300, 40, 0, 0);
      run_setting(2, 1, 2, 40, 200, 0, 0);

      // random settings, mostly whole frames with random content
      while (items_queued < 850) begin
         kh = $urandom_range(9, 1);
         kw = $urandom_range(9, 2);
         lw = $urandom_range(24, 2);
         sel = $urandom_range(3);
         b = (sel == 0) ? 0 : (sel == 1) ? 65535 : (sel == 2) ? $urandom_range(512)
                                                             : $urandom_range(65535);
         run_setting(lw, kh, kw, b, lw * (kh + $urandom_range(3)), $urandom_range(3),
                     ($urandom_range(9) == 0) ? 4 : 0);
      end
      wait_idle();
      if (failed || expected_results.size() != 0) begin
         $display("Regression FAIL");
      end else begin
         $display("Regression PASS");
      end
      $finish;
   end

   initial begin
      #(12 * 3000000);
      $display("Regression FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/lcn_pkg.sv
sv/lcn_if.sv
sv/local_contrast_normalize.sv
sv/lcn_check.sv
test/testbench.sv
